/* design/set_assoc_cache_lfu_marking_replacement_defines.svh */
// Assertion macros shared by the cache controller files.
`ifndef SET_ASSOC_CACHE_LFU_MARKING_REPLACEMENT_DEFINES_SVH
`define SET_ASSOC_CACHE_LFU_MARKING_REPLACEMENT_DEFINES_SVH

// Property must hold from the cycle after the antecedent.
`define SAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Property must hold in the same cycle.
`define SAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* design/sac_pkg.sv */
package sac_pkg;
  localparam int Sets      = 64;
  localparam int Ways      = 8;
  localparam int LineBytes = 64;
  localparam int AddrBits  = 32;

  localparam int OffBits = $clog2(LineBytes);
  localparam int SetBits = $clog2(Sets);
  localparam int WayBits = $clog2(Ways);
  localparam int TagBits = AddrBits - OffBits - SetBits;
  localparam int CntBits = $clog2(Ways + 1);

  localparam logic POLICY_LFU  = 1'b0;
  localparam logic POLICY_MARK = 1'b1;

  typedef logic [SetBits-1:0] set_t;
  typedef logic [WayBits-1:0] way_t;
  typedef logic [TagBits-1:0] tag_t;
  typedef logic [CntBits-1:0] mcnt_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture request, start set read
    logic lookup;  // register tag compare and line state
    logic decide;  // pick way, compute new line state
    logic reorder; // one bubble step of the priority list
    logic commit;  // write back set state, update totals
  } sac_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic reorder_done;
  } sac_sts_t;
endpackage

/* design/sac_datapath.sv */
module sac_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  sac_pkg::sac_cmd_t    cmd,
  output sac_pkg::sac_sts_t    sts,
  input  logic                 policy,
  input  logic [63:0]          req_data,
  output logic [79:0]          rsp_data
);
  import sac_pkg::*;
  `include "set_assoc_cache_lfu_marking_replacement_defines.svh"

  // Per-set rows, one address a cycle: read whole; written whole but tag_mem.
  logic [Ways*TagBits-1:0] tag_mem  [Sets];
  logic [Ways*32-1:0]      use_mem  [Sets];
  logic [Ways*32-1:0]      age_mem  [Sets];
  logic [Ways*WayBits-1:0] ord_mem  [Sets];
  logic [Ways-1:0]         vld_mem  [Sets];
  mcnt_t                   mrk_mem  [Sets];
  logic [Sets-1:0]         row_init;          // row has left its reset value

  tag_t         tag;
  set_t         set_idx;
  logic [31:0]  rnd;
  logic [Ways*TagBits-1:0] tag_row;
  logic [Ways*32-1:0]      use_rd, age_rd;
  logic [Ways*WayBits-1:0] ord_rd;
  logic [Ways-1:0]         vld_rd;
  mcnt_t                   mrk_rd;

  // working copy of the selected set
  logic [31:0]  use_c [Ways];
  logic [31:0]  age_c [Ways];
  way_t         ord_c [Ways];
  logic [Ways-1:0] vld_c;
  mcnt_t        mcnt_c;
  logic [Ways-1:0] match_q;
  way_t         start_q;
  logic         hit;
  way_t         way;
  logic [31:0]  global_age, acc_cnt, miss_cnt;
  logic [WayBits:0] pos;        // position of moving way in order
  logic [31:0]  cur_prio;

  // v mod d for d in 1..Ways: powers of two by mask, the rest from the
  // quotient by reciprocal multiply (exact over all 32-bit v); the
  // remainder is below Ways, so only the low bits of q*d are needed
  function automatic way_t mod_ways(logic [31:0] v, logic [WayBits:0] d);
    logic [33:0] recip;
    logic [65:0] prod;
    way_t        quo_lo;
    way_t        qd_lo;
    case (d)
      4'd3:    recip = 34'd11453246123;
      4'd5:    recip = 34'd6871947674;
      4'd6:    recip = 34'd5726623062;
      4'd7:    recip = 34'd4908534053;
      default: recip = '0;
    endcase
    prod   = {34'd0, v} * {32'd0, recip};
    quo_lo = prod[35 +: WayBits];
    qd_lo  = way_t'(quo_lo * d[WayBits-1:0]);
    if (recip == '0) return v[WayBits-1:0] & way_t'(d - 1'b1);
    return v[WayBits-1:0] - qd_lo;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag     <= req_data[AddrBits-1 -: TagBits];
      set_idx <= req_data[OffBits +: SetBits];
      rnd     <= req_data[63:32];
    end
  end

  // registered row read
  always_ff @(posedge clk) begin
    tag_row <= tag_mem[set_idx];
    use_rd  <= use_mem[set_idx];
    age_rd  <= age_mem[set_idx];
    ord_rd  <= ord_mem[set_idx];
    vld_rd  <= vld_mem[set_idx];
    mrk_rd  <= mrk_mem[set_idx];
  end

  // lookup: rows never written read as their reset values
  logic [Ways-1:0]  vld, match;
  mcnt_t            mcnt;
  logic [WayBits:0] modv;
  always_comb begin
    vld  = row_init[set_idx] ? vld_rd : '0;
    mcnt = row_init[set_idx] ? mrk_rd : '0;
    match = '0;
    for (int w = 0; w < Ways; w++)
      match[w] = vld[w] && (tag_row[w*TagBits +: TagBits] == tag);
    // a full mark count is cleared before the victim draw
    if (mcnt >= mcnt_t'(Ways)) modv = (WayBits+1)'(Ways);
    else modv = (WayBits+1)'(Ways) - (WayBits+1)'(mcnt);
  end

  // decide: pick the way and the new line state
  way_t        hit_way, first_inv, scan_w, way_sel;
  logic        any_inv, found, clr_all, lfu_evict;
  logic [Ways-1:0] unm;
  logic [31:0] use_eff [Ways];
  logic [31:0] use_new [Ways];
  logic [31:0] age_new [Ways];
  mcnt_t       mcnt_eff, mcnt_new;
  logic [31:0] victim_prio;
  always_comb begin
    hit_way = '0;
    for (int w = Ways-1; w >= 0; w--) if (match_q[w]) hit_way = way_t'(w);
    first_inv = '0; any_inv = 1'b0;
    for (int w = Ways-1; w >= 0; w--)
      if (!vld_c[w]) begin first_inv = way_t'(w); any_inv = 1'b1; end
    clr_all  = (mcnt_c >= mcnt_t'(Ways));
    mcnt_eff = clr_all ? '0 : mcnt_c;
    for (int w = 0; w < Ways; w++) begin
      use_eff[w] = clr_all ? '0 : use_c[w];
      unm[w]     = (use_eff[w] == '0);
    end
    found = 1'b0; scan_w = start_q;
    for (int k = 0; k < Ways; k++) begin
      if (!found && unm[way_t'(start_q + way_t'(k))]) begin
        found = 1'b1; scan_w = way_t'(start_q + way_t'(k));
      end
    end
    victim_prio = age_c[ord_c[Ways-1]] + use_c[ord_c[Ways-1]];
    lfu_evict = 1'b0;
    mcnt_new  = mcnt_c;
    way_sel   = '0;
    for (int w = 0; w < Ways; w++) begin
      use_new[w] = use_c[w];
      age_new[w] = age_c[w];
    end
    if (|match_q) begin
      way_sel = hit_way;
      use_new[hit_way] = use_c[hit_way] + 32'd1;
      if (policy == POLICY_LFU) age_new[hit_way] = global_age;
      else if (use_c[hit_way] == '0 && mcnt_c < mcnt_t'(Ways)) mcnt_new = mcnt_c + 1'b1;
    end else if (any_inv) begin
      way_sel = first_inv;
      use_new[first_inv] = 32'd1;
      if (policy == POLICY_LFU) age_new[first_inv] = global_age;
      if (mcnt_c < mcnt_t'(Ways)) mcnt_new = mcnt_c + 1'b1;
    end else if (policy == POLICY_LFU) begin
      // dynamic aging: victim is the tail of the order
      way_sel   = ord_c[Ways-1];
      lfu_evict = 1'b1;
      age_new[ord_c[Ways-1]] = victim_prio;
      use_new[ord_c[Ways-1]] = 32'd1;
    end else begin
      // no unmarked way despite the count: keep the start way
      way_sel = found ? scan_w : start_q;
      for (int w = 0; w < Ways; w++) use_new[w] = use_eff[w];
      use_new[way_sel] = 32'd1;
      mcnt_new = mcnt_eff + 1'b1;
    end
  end

  // locate moving way in order, then bubble one step a cycle
  logic [31:0] pr_f [Ways];
  way_t mv_way;
  logic mv_active;
  always_comb begin
    mv_way = way;
    pos = (WayBits+1)'(Ways);
    for (int p = Ways-1; p >= 0; p--) if (ord_c[p] == mv_way) pos = (WayBits+1)'(p);
    cur_prio = age_c[mv_way] + use_c[mv_way];
    for (int p = 0; p < Ways; p++) pr_f[p] = age_c[ord_c[p]] + use_c[ord_c[p]];
  end
  logic [WayBits-1:0] pm1;
  always_comb begin
    pm1 = WayBits'(pos - 1'b1);
    mv_active = (policy == POLICY_LFU) && (pos != '0) &&
                (pos != (WayBits+1)'(Ways)) && (pr_f[pm1] <= cur_prio);
    sts.reorder_done = !mv_active;
  end

  // working set: load on lookup, update on decide, reorder step by step
  always_ff @(posedge clk) begin
    if (rst) begin
      global_age <= '0;
    end else if (cmd.lookup) begin
      match_q <= match;
      vld_c   <= vld;
      mcnt_c  <= mcnt;
      start_q <= mod_ways(rnd, modv);
      for (int w = 0; w < Ways; w++) begin
        if (row_init[set_idx]) begin
          use_c[w] <= use_rd[w*32 +: 32];
          age_c[w] <= age_rd[w*32 +: 32];
          ord_c[w] <= ord_rd[w*WayBits +: WayBits];
        end else begin
          use_c[w] <= '0;
          age_c[w] <= '0;
          ord_c[w] <= way_t'(w);
        end
      end
    end else if (cmd.decide) begin
      hit    <= |match_q;
      way    <= way_sel;
      mcnt_c <= mcnt_new;
      if (!(|match_q)) vld_c[way_sel] <= 1'b1;
      if (lfu_evict) global_age <= victim_prio;
      for (int w = 0; w < Ways; w++) begin
        use_c[w] <= use_new[w];
        age_c[w] <= age_new[w];
      end
    end else if (cmd.reorder && mv_active) begin
      ord_c[pm1]            <= mv_way;
      ord_c[WayBits'(pos)]  <= ord_c[pm1];
    end
  end

  logic [Ways*32-1:0]      use_row, age_row;
  logic [Ways*WayBits-1:0] ord_row;
  always_comb begin
    for (int w = 0; w < Ways; w++) begin
      use_row[w*32 +: 32]           = use_c[w];
      age_row[w*32 +: 32]           = age_c[w];
      ord_row[w*WayBits +: WayBits] = ord_c[w];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      use_mem[set_idx] <= use_row;
      age_mem[set_idx] <= age_row;
      ord_mem[set_idx] <= ord_row;
      vld_mem[set_idx] <= vld_c;
      mrk_mem[set_idx] <= mcnt_c;
      if (!hit) tag_mem[set_idx][way*TagBits +: TagBits] <= tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_init <= '0;
      acc_cnt  <= '0;
      miss_cnt <= '0;
    end else if (cmd.commit) begin
      row_init[set_idx] <= 1'b1;
      acc_cnt <= acc_cnt + 32'd1;
      if (!hit) miss_cnt <= miss_cnt + 32'd1;
      rsp_data <= {6'b0, !hit ? miss_cnt + 32'd1 : miss_cnt, acc_cnt + 32'd1,
                   set_idx, way, hit};
    end
  end

  `SAC_ASSERT_NEXT(a_commit_init, cmd.commit, row_init[set_idx], "committed row not marked")
  `SAC_ASSERT_NOW(a_way_valid, cmd.commit, vld_c[way], "committed way not valid")
  `SAC_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0(cmd), "overlapping datapath commands")
  `SAC_ASSERT_NOW(a_mark_bound, cmd.decide, mcnt_c <= mcnt_t'(Ways), "mark count past way count")
endmodule

/* design/sac_ctrl.sv */
module sac_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              out_busy,
  input  sac_pkg::sac_sts_t sts,
  output sac_pkg::sac_cmd_t cmd,
  output logic              idle,
  output logic              rsp_set
);
  import sac_pkg::*;
  `include "set_assoc_cache_lfu_marking_replacement_defines.svh"

  typedef enum logic [2:0] {S_IDLE, S_READ, S_LOOK, S_DECIDE, S_REORD, S_COMMIT} state_t;
  state_t state;

  always_comb begin
    cmd = '0;
    cmd.load    = in_fire;
    cmd.lookup  = (state == S_LOOK);
    cmd.decide  = (state == S_DECIDE);
    cmd.reorder = (state == S_REORD);
    cmd.commit  = (state == S_COMMIT) && !out_busy;
    idle        = (state == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rsp_set <= 1'b0;
    end else begin
      rsp_set <= cmd.commit;
      case (state)
        S_IDLE:   if (in_fire) state <= S_READ;
        S_READ:   state <= S_LOOK;
        S_LOOK:   state <= S_DECIDE;
        S_DECIDE: state <= S_REORD;
        S_REORD:  if (sts.reorder_done) state <= S_COMMIT;
        S_COMMIT: if (!out_busy) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  `SAC_ASSERT_NEXT(a_fire_idle, in_fire, state == S_READ, "request taken outside idle")
  `SAC_ASSERT_NEXT(a_commit_rsp, cmd.commit, rsp_set, "commit without response")
  `SAC_ASSERT_NOW(a_no_fire_busy, state != S_IDLE, !in_fire, "request accepted while busy")
endmodule

/* design/set_assoc_cache_lfu_marking_replacement.sv */
// Tag and replacement controller of a 64-set, 8-way read cache with 64-byte
// lines. Each request (address, random word) yields one response giving hit,
// way, set and running access/miss totals. Policy 0 is LFU with dynamic aging,
// policy 1 randomized marking; write it only while idle. One request at a time:
// each passes through read, lookup, decide, reorder (up to 7 priority-list
// steps, one swap a cycle) and commit; commit sets a response flag register,
// from which m_tvalid is registered, and s_tready returns once commit is done.
// A result waits in the output register while the next request is accepted;
// that request then holds in commit until the waiting result is taken.
module set_assoc_cache_lfu_marking_replacement (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,       // replacement_policy
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,        // address[31:0], random_value[63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata         // hit, way[3:1], set_index[9:4],
                                      // access_total[41:10], miss_total[73:42]
);
  import sac_pkg::*;

  sac_cmd_t cmd;
  sac_sts_t sts;
  logic policy, idle, rsp_set, in_fire;

  assign cfg_ready = 1'b1;
  assign s_tready  = idle;
  assign in_fire   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) policy <= POLICY_LFU;
    else if (cfg_valid) policy <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (rsp_set) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  sac_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire),
    .out_busy(m_tvalid && !m_tready), .sts(sts), .cmd(cmd),
    .idle(idle), .rsp_set(rsp_set)
  );

  sac_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .policy(policy),
    .req_data(s_tdata), .rsp_data(m_tdata)
  );
endmodule
